/* design/bsre_pkg.sv */
// ----------------------------------------------------------------------------
// Bitmap scaled rectangle emitter package
// Shared types and constants for the bitmap rectangle renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package bsre_pkg;

  localparam int SCR_BITS  = 12;
  localparam int CODE_BITS = 8;
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_RECT  = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  localparam logic [1:0] REG_SCREEN_W = 2'd0;
  localparam logic [1:0] REG_SCREEN_H = 2'd1;
  localparam logic [1:0] REG_CODE_W   = 2'd2;
  localparam logic [1:0] REG_CODE_H   = 2'd3;

  localparam logic [SCR_BITS-1:0]  SCREEN_W_RST = 12'd240;
  localparam logic [SCR_BITS-1:0]  SCREEN_H_RST = 12'd240;
  localparam logic [CODE_BITS-1:0] CODE_W_RST   = 8'd25;
  localparam logic [CODE_BITS-1:0] CODE_H_RST   = 8'd25;

  typedef struct packed {
    logic       clear;
    logic       flush;
    logic [7:0] mask;
  } job_ctl_t;

endpackage

`default_nettype wire

/* design/bsre_div.sv */
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division of a screen size by a code size, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bsre_div (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic [bsre_pkg::SCR_BITS-1:0]      dividend,
  input  wire logic [bsre_pkg::CODE_BITS-1:0]     divisor,
  output logic                                    done,
  output logic [bsre_pkg::SCR_BITS-1:0]           quotient
);

  localparam int NB = bsre_pkg::SCR_BITS;
  localparam int DB = bsre_pkg::CODE_BITS;
  localparam int CB = $clog2(NB);

  logic [NB-1:0] qd_r;
  logic [DB-1:0] rem_r;
  logic [DB-1:0] dvs_r;
  logic [CB-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DB:0]   rem_sh;
  logic          fits;

  always_comb begin
    rem_sh = {rem_r, qd_r[NB-1]};
    fits   = rem_sh >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        qd_r   <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        qd_r  <= {qd_r[NB-2:0], fits};
        rem_r <= fits ? DB'(rem_sh - {1'b0, dvs_r}) : rem_sh[DB-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CB'(NB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = qd_r;

endmodule

`default_nettype wire

/* design/bsre_front.sv */
// ----------------------------------------------------------------------------
// Front end
// Accepts bitmap bytes, sets up scale and offsets at frame start, tracks the
// row and column, and turns each byte that has work into a rendering job.
// ----------------------------------------------------------------------------
`default_nettype none

module bsre_front #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      in_byte,
  input  wire logic [bsre_pkg::SCR_BITS-1:0]   screen_w,
  input  wire logic [bsre_pkg::SCR_BITS-1:0]   screen_h,
  input  wire logic [bsre_pkg::CODE_BITS-1:0]  code_w,
  input  wire logic [bsre_pkg::CODE_BITS-1:0]  code_h,
  output logic                                 job_valid,
  input  wire logic                            job_ready,
  output bsre_pkg::job_ctl_t                   job_ctl,
  output logic [COORD_BITS+9:0]                job_x,
  output logic [COORD_BITS+9:0]                job_y,
  output logic [COORD_BITS-1:0]                job_scale
);

  localparam int C  = COORD_BITS;
  localparam int WB = COORD_BITS + 10;
  localparam int PW = COORD_BITS + bsre_pkg::CODE_BITS;
  localparam int SB = bsre_pkg::SCR_BITS;
  localparam int KB = bsre_pkg::CODE_BITS;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_DIV  = 5'b00010,
    F_MUL  = 5'b00100,
    F_OFS  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t       state_r, state_nxt;
  logic [7:0]    byte_r;
  logic          active_r;
  logic          clear_pend_r;
  logic          zero_div_r;
  logic [KB-1:0] row_r;
  logic [KB-1:0] col_r;
  logic [C-1:0]  scale_r;
  logic [C-1:0]  off_x_r;
  logic [PW-1:0] prod_w_r;
  logic [PW-1:0] prod_h_r;
  logic [WB-1:0] x_base_r;
  logic [WB-1:0] y_base_r;

  logic          accept;
  logic          div_start;
  logic          div_done;
  logic [SB-1:0] div_q;
  logic [SB-1:0] div_num;
  logic [KB-1:0] div_den;
  logic [PW-1:0] gap_x;
  logic [PW-1:0] gap_y;
  logic [C-1:0]  off_x;
  logic [C-1:0]  off_y;
  logic          act;
  logic [7:0]    mask;
  logic [KB:0]   col_pos;
  logic [KB:0]   col8;
  logic          row_end;
  logic [KB:0]   row_after;
  logic          flush;
  logic          has_work;
  logic          push_done;

  always_comb begin
    accept    = in_valid && (state_r == F_IDLE);
    div_start = accept && !active_r;
    if (screen_w <= screen_h) begin
      div_num = screen_w;
      div_den = code_w;
    end else begin
      div_num = screen_h;
      div_den = code_h;
    end

    gap_x = (PW'(screen_w) > prod_w_r) ? ((PW'(screen_w) - prod_w_r) >> 1) : '0;
    gap_y = (PW'(screen_h) > prod_h_r) ? ((PW'(screen_h) - prod_h_r) >> 1) : '0;
    off_x = (|gap_x[PW-1:C]) ? {C{1'b1}} : gap_x[C-1:0];
    off_y = (|gap_y[PW-1:C]) ? {C{1'b1}} : gap_y[C-1:0];

    act = row_r < code_h;
    for (int i = 0; i < 8; i++) begin
      col_pos     = {1'b0, col_r} + (KB+1)'(i);
      mask[7 - i] = act && (col_pos < {1'b0, code_w}) && !byte_r[7 - i];
    end
    col8      = {1'b0, col_r} + (KB+1)'(8);
    row_end   = act && (col8 >= {1'b0, code_w});
    row_after = row_end ? ({1'b0, row_r} + (KB+1)'(1)) : {1'b0, row_r};
    flush     = row_after >= {1'b0, code_h};
    has_work  = clear_pend_r || (|mask) || flush;
    push_done = (state_r == F_PUSH) && (!has_work || job_ready);

    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = active_r ? F_PUSH : F_DIV;
        end
      end
      F_DIV: begin
        if (div_done) begin
          state_nxt = F_MUL;
        end
      end
      F_MUL:  state_nxt = F_OFS;
      F_OFS:  state_nxt = F_PUSH;
      F_PUSH: begin
        if (push_done) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= F_IDLE;
      active_r     <= 1'b0;
      clear_pend_r <= 1'b0;
      row_r        <= '0;
      col_r        <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            byte_r     <= in_byte;
            zero_div_r <= (div_den == '0);
          end
        end
        F_DIV: begin
          if (div_done) begin
            scale_r <= zero_div_r ? '0 : C'(div_q);
          end
        end
        F_MUL: begin
          prod_w_r <= PW'(scale_r) * PW'(code_w);
          prod_h_r <= PW'(scale_r) * PW'(code_h);
        end
        F_OFS: begin
          off_x_r      <= off_x;
          x_base_r     <= WB'(off_x);
          y_base_r     <= WB'(off_y);
          row_r        <= '0;
          col_r        <= '0;
          active_r     <= 1'b1;
          clear_pend_r <= 1'b1;
        end
        F_PUSH: begin
          if (push_done) begin
            clear_pend_r <= 1'b0;
            if (flush) begin
              active_r <= 1'b0;
              row_r    <= '0;
              col_r    <= '0;
            end else if (row_end) begin
              row_r    <= row_after[KB-1:0];
              col_r    <= '0;
              x_base_r <= WB'(off_x_r);
              y_base_r <= y_base_r + WB'(scale_r);
            end else begin
              col_r    <= col8[KB-1:0];
              x_base_r <= x_base_r + (WB'(scale_r) << 3);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  bsre_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_ready      = (state_r == F_IDLE);
  assign job_valid     = (state_r == F_PUSH) && has_work;
  assign job_ctl.clear = clear_pend_r;
  assign job_ctl.flush = flush;
  assign job_ctl.mask  = mask;
  assign job_x         = x_base_r;
  assign job_y         = y_base_r;
  assign job_scale     = scale_r;

endmodule

`default_nettype wire

/* design/bsre_fifo.sv */
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bsre_fifo #(
  parameter int W = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire logic [W-1:0]  wr_data,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output logic [W-1:0]       rd_data
);

  logic [W-1:0] mem_r [2];
  logic         wptr_r;
  logic         rptr_r;
  logic [1:0]   cnt_r;
  logic         wr_en;
  logic         rd_en;

  always_comb begin
    wr_ready = (cnt_r != 2'd2);
    rd_valid = (cnt_r != 2'd0);
    wr_en    = wr_valid && wr_ready;
    rd_en    = rd_valid && rd_ready;
    rd_data  = mem_r[rptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr_en) begin
        wptr_r <= ~wptr_r;
      end
      if (rd_en) begin
        rptr_r <= ~rptr_r;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* design/bsre_back.sv */
// ----------------------------------------------------------------------------
// Back end
// Executes rendering jobs: clear, one rectangle per black module, and flush,
// into a registered output stage; a new job is taken only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module bsre_back #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  job_valid,
  output logic                       job_ready,
  input  wire bsre_pkg::job_ctl_t    job_ctl,
  input  wire logic [COORD_BITS+9:0] job_x,
  input  wire logic [COORD_BITS+9:0] job_y,
  input  wire logic [COORD_BITS-1:0] job_scale,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_cmd,
  output logic [COORD_BITS-1:0]      out_left,
  output logic [COORD_BITS-1:0]      out_top,
  output logic [COORD_BITS-1:0]      out_right,
  output logic [COORD_BITS-1:0]      out_bottom,
  output logic                       out_last
);

  localparam int C  = COORD_BITS;
  localparam int WB = COORD_BITS + 10;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_CLR   = 4'b0010,
    B_RECT  = 4'b0100,
    B_FLUSH = 4'b1000
  } bstate_t;

  bstate_t       state_r;
  logic          flush_r;
  logic [7:0]    mask_r;
  logic [WB-1:0] x_r;
  logic [WB-1:0] y_r;
  logic [C-1:0]  scale_r;
  logic          out_valid_r;
  logic [1:0]    out_cmd_r;
  logic [C-1:0]  out_left_r;
  logic [C-1:0]  out_top_r;
  logic [C-1:0]  out_right_r;
  logic [C-1:0]  out_bottom_r;
  logic          out_last_r;

  logic          adv;
  logic [7:0]    rem_mask;
  logic [WB-1:0] x_right;
  logic [WB-1:0] y_bot;
  logic [C-1:0]  sat_l;
  logic [C-1:0]  sat_t;
  logic [C-1:0]  sat_r;
  logic [C-1:0]  sat_b;

  always_comb begin
    adv       = !out_valid_r || out_ready;
    rem_mask  = {mask_r[6:0], 1'b0};
    x_right   = x_r + WB'(scale_r);
    y_bot     = y_r + WB'(scale_r);
    sat_l     = (|x_r[WB-1:C])     ? {C{1'b1}} : x_r[C-1:0];
    sat_t     = (|y_r[WB-1:C])     ? {C{1'b1}} : y_r[C-1:0];
    sat_r     = (|x_right[WB-1:C]) ? {C{1'b1}} : x_right[C-1:0];
    sat_b     = (|y_bot[WB-1:C])   ? {C{1'b1}} : y_bot[C-1:0];
    job_ready = (state_r == B_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (job_valid) begin
            flush_r <= job_ctl.flush;
            mask_r  <= job_ctl.mask;
            x_r     <= job_x;
            y_r     <= job_y;
            scale_r <= job_scale;
            if (job_ctl.clear) begin
              state_r <= B_CLR;
            end else if (|job_ctl.mask) begin
              state_r <= B_RECT;
            end else begin
              state_r <= B_FLUSH;
            end
          end
        end
        B_CLR: begin
          if (adv) begin
            out_valid_r  <= 1'b1;
            out_cmd_r    <= bsre_pkg::CMD_CLEAR;
            out_left_r   <= '0;
            out_top_r    <= '0;
            out_right_r  <= '0;
            out_bottom_r <= '0;
            out_last_r   <= (mask_r == 8'd0) && !flush_r;
            if (|mask_r) begin
              state_r <= B_RECT;
            end else if (flush_r) begin
              state_r <= B_FLUSH;
            end else begin
              state_r <= B_IDLE;
            end
          end
        end
        B_RECT: begin
          if (!mask_r[7] || adv) begin
            if (mask_r[7]) begin
              out_valid_r  <= 1'b1;
              out_cmd_r    <= bsre_pkg::CMD_RECT;
              out_left_r   <= sat_l;
              out_top_r    <= sat_t;
              out_right_r  <= sat_r;
              out_bottom_r <= sat_b;
              out_last_r   <= (rem_mask == 8'd0) && !flush_r;
            end
            mask_r <= rem_mask;
            x_r    <= x_right;
            if (rem_mask == 8'd0) begin
              state_r <= flush_r ? B_FLUSH : B_IDLE;
            end
          end
        end
        B_FLUSH: begin
          if (adv) begin
            out_valid_r  <= 1'b1;
            out_cmd_r    <= bsre_pkg::CMD_FLUSH;
            out_left_r   <= '0;
            out_top_r    <= '0;
            out_right_r  <= '0;
            out_bottom_r <= '0;
            out_last_r   <= 1'b1;
            state_r      <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_cmd    = out_cmd_r;
  assign out_left   = out_left_r;
  assign out_top    = out_top_r;
  assign out_right  = out_right_r;
  assign out_bottom = out_bottom_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

/* design/bitmap_scaled_rect_emitter_core.sv */
// ----------------------------------------------------------------------------
// Bitmap scaled rectangle emitter
// Renders a 1-bit bitmap as drawing commands: clear, black rectangles, flush.
//
// The in_ stream carries one bitmap byte per transaction, MSB first, rows
// padded to whole bytes. The out_ stream carries one command per
// transaction; out_tlast marks the last command caused by an input byte.
// Screen and bitmap sizes are written through the cfg_ APB port; the user
// must write them only while idle, as the block itself does not enforce it.
// Setup of a frame's first byte: the bit-serial divider finds the scale,
// then the products and then the centering offsets are registered. After
// that the front end takes a new byte only once the job for the last one is
// in the queue. The back end takes a job when idle, emits the clear if asked,
// steps through the bit positions up to the last black module of the byte,
// then the flush if asked. A two-entry job queue sits between the two halves,
// so the front end keeps accepting bytes while the output register holds a
// command the receiver has not taken. A stalled receiver holds out_ data and
// stops the back end. Reset empties the queue and ends any frame; the
// registers return to a 240 by 240 screen and a 25 by 25 bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_scaled_rect_emitter_core #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // bitmap_byte[7:0]
  input  wire logic [7:0]                           in_tdata,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // left_x, top_y, right_x, bottom_y, each COORD_BITS wide, zero padded
  output logic [((4*COORD_BITS+7)/8)*8-1:0]         out_tdata,
  // command[1:0]
  output logic [1:0]                                out_tuser,
  output logic                                      out_tlast,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [bsre_pkg::ADDR_BITS-1:0]       cfg_paddr,
  input  wire logic [bsre_pkg::DATA_BITS-1:0]       cfg_pwdata,
  output logic [bsre_pkg::DATA_BITS-1:0]            cfg_prdata,
  output logic                                      cfg_pready
);

  localparam int C   = COORD_BITS;
  localparam int WB  = COORD_BITS + 10;
  localparam int TDW = ((4*COORD_BITS+7)/8)*8;
  localparam int CTW = $bits(bsre_pkg::job_ctl_t);
  localparam int QW  = CTW + 2*WB + C;
  localparam int SB  = bsre_pkg::SCR_BITS;
  localparam int KB  = bsre_pkg::CODE_BITS;
  localparam int DW  = bsre_pkg::DATA_BITS;

  logic [SB-1:0] screen_w_r;
  logic [SB-1:0] screen_h_r;
  logic [KB-1:0] code_w_r;
  logic [KB-1:0] code_h_r;
  logic          cfg_wr;

  bsre_pkg::job_ctl_t f_ctl;
  bsre_pkg::job_ctl_t b_ctl;
  logic               f_valid;
  logic               f_ready;
  logic [WB-1:0]      f_x;
  logic [WB-1:0]      f_y;
  logic [C-1:0]       f_scale;
  logic               b_valid;
  logic               b_ready;
  logic [QW-1:0]      b_data;
  logic [WB-1:0]      b_x;
  logic [WB-1:0]      b_y;
  logic [C-1:0]       b_scale;
  logic [C-1:0]       o_left;
  logic [C-1:0]       o_top;
  logic [C-1:0]       o_right;
  logic [C-1:0]       o_bottom;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= bsre_pkg::SCREEN_W_RST;
      screen_h_r <= bsre_pkg::SCREEN_H_RST;
      code_w_r   <= bsre_pkg::CODE_W_RST;
      code_h_r   <= bsre_pkg::CODE_H_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        bsre_pkg::REG_SCREEN_W: screen_w_r <= cfg_pwdata[SB-1:0];
        bsre_pkg::REG_SCREEN_H: screen_h_r <= cfg_pwdata[SB-1:0];
        bsre_pkg::REG_CODE_W:   code_w_r   <= cfg_pwdata[KB-1:0];
        bsre_pkg::REG_CODE_H:   code_h_r   <= cfg_pwdata[KB-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      bsre_pkg::REG_SCREEN_W: cfg_prdata = DW'(screen_w_r);
      bsre_pkg::REG_SCREEN_H: cfg_prdata = DW'(screen_h_r);
      bsre_pkg::REG_CODE_W:   cfg_prdata = DW'(code_w_r);
      bsre_pkg::REG_CODE_H:   cfg_prdata = DW'(code_h_r);
      default:                cfg_prdata = '0;
    endcase
  end

  bsre_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .screen_w  (screen_w_r),
    .screen_h  (screen_h_r),
    .code_w    (code_w_r),
    .code_h    (code_h_r),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job_ctl   (f_ctl),
    .job_x     (f_x),
    .job_y     (f_y),
    .job_scale (f_scale)
  );

  bsre_fifo #(
    .W (QW)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  ({f_ctl, f_x, f_y, f_scale}),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  assign {b_ctl, b_x, b_y, b_scale} = b_data;

  bsre_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (b_valid),
    .job_ready  (b_ready),
    .job_ctl    (b_ctl),
    .job_x      (b_x),
    .job_y      (b_y),
    .job_scale  (b_scale),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_cmd    (out_tuser),
    .out_left   (o_left),
    .out_top    (o_top),
    .out_right  (o_right),
    .out_bottom (o_bottom),
    .out_last   (out_tlast)
  );

  assign out_tdata = TDW'({o_bottom, o_right, o_top, o_left});

endmodule

`default_nettype wire

/* tb/bsre_draw_monitor.sv */
// ----------------------------------------------------------------------------
// Draw command monitor for the bitmap rectangle emitter
// Watches the register port, the bitmap byte stream and the command stream.
// It keeps its own copy of the screen and bitmap geometry and of the frame
// position, predicts the commands that each accepted byte must cause, and
// compares every accepted command with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsre_draw_monitor #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [7:0]                           in_tdata,
  input  wire logic                                 in_tvalid,
  input  wire logic                                 in_tready,
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]    out_tdata,
  input  wire logic [1:0]                           out_tuser,
  input  wire logic                                 out_tlast,
  input  wire logic                                 out_tvalid,
  input  wire logic                                 out_tready,
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [bsre_pkg::ADDR_BITS-1:0]       cfg_paddr,
  input  wire logic [bsre_pkg::DATA_BITS-1:0]       cfg_pwdata,
  input  wire logic                                 cfg_pready,
  output int                                        fail_count,
  output int                                        pending_count
);

  localparam logic [31:0] COORD_MAX = (32'd1 << COORD_BITS) - 32'd1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [1:0] cmd;
    coord_t     left_x;
    coord_t     top_y;
    coord_t     right_x;
    coord_t     bottom_y;
    logic       last;
  } draw_cmd_t;

  draw_cmd_t                      draw_queue[$];
  logic [bsre_pkg::SCR_BITS-1:0]  scr_w;
  logic [bsre_pkg::SCR_BITS-1:0]  scr_h;
  logic [bsre_pkg::CODE_BITS-1:0] mod_w;
  logic [bsre_pkg::CODE_BITS-1:0] mod_h;
  logic                           in_frame;
  logic [7:0]                     row;
  logic [7:0]                     col;
  coord_t                         pitch;
  coord_t                         org_x;
  coord_t                         org_y;
  int                             errors = 0;

  function automatic coord_t clip(input logic [31:0] v);
    return (v > COORD_MAX) ? coord_t'(COORD_MAX) : coord_t'(v);
  endfunction

  function automatic logic [31:0] margin(input logic [31:0] total, input logic [31:0] used);
    return (total > used) ? (total - used) / 32'd2 : 32'd0;
  endfunction

  function automatic draw_cmd_t make_cmd(input logic [1:0] cmd, input coord_t x1,
                                         input coord_t y1, input coord_t x2,
                                         input coord_t y2);
    draw_cmd_t c;
    c.cmd      = cmd;
    c.left_x   = x1;
    c.top_y    = y1;
    c.right_x  = x2;
    c.bottom_y = y2;
    c.last     = 1'b0;
    return c;
  endfunction

  task automatic render_byte(input logic [7:0] pixels);
    logic [7:0]  bits;
    logic [31:0] span;
    logic [31:0] x0;
    logic [31:0] y0;
    draw_cmd_t   batch [11];
    int          n;
    bits = pixels;
    n    = 0;
    if (!in_frame) begin
      if (scr_w <= scr_h) begin
        span = (mod_w != 0) ? 32'(scr_w) / 32'(mod_w) : 32'd0;
      end else begin
        span = (mod_h != 0) ? 32'(scr_h) / 32'(mod_h) : 32'd0;
      end
      pitch    = coord_t'(span & COORD_MAX);
      org_x    = clip(margin(32'(scr_w), 32'(pitch) * 32'(mod_w)));
      org_y    = clip(margin(32'(scr_h), 32'(pitch) * 32'(mod_h)));
      row      = '0;
      col      = '0;
      in_frame = 1'b1;
      batch[n] = make_cmd(bsre_pkg::CMD_CLEAR, '0, '0, '0, '0);
      n++;
    end
    if (row < mod_h) begin
      for (int b = 0; b < 8 && col < mod_w; b++) begin
        if (!bits[7]) begin
          x0       = 32'(org_x) + 32'(pitch) * 32'(col);
          y0       = 32'(org_y) + 32'(pitch) * 32'(row);
          batch[n] = make_cmd(bsre_pkg::CMD_RECT, clip(x0), clip(y0),
                              clip(x0 + 32'(pitch)), clip(y0 + 32'(pitch)));
          n++;
        end
        bits = bits << 1;
        col++;
      end
      if (col >= mod_w) begin
        col = '0;
        if (row != 8'hFF) begin
          row++;
        end
      end
    end
    if (row >= mod_h) begin
      batch[n] = make_cmd(bsre_pkg::CMD_FLUSH, '0, '0, '0, '0);
      n++;
      in_frame = 1'b0;
      row      = '0;
      col      = '0;
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) begin
        batch[i].last = 1'b1;
      end
      draw_queue.push_back(batch[i]);
    end
  endtask

  task automatic check_command();
    draw_cmd_t got;
    draw_cmd_t want;
    got.cmd      = out_tuser;
    got.left_x   = out_tdata[COORD_BITS-1:0];
    got.top_y    = out_tdata[2*COORD_BITS-1:COORD_BITS];
    got.right_x  = out_tdata[3*COORD_BITS-1:2*COORD_BITS];
    got.bottom_y = out_tdata[4*COORD_BITS-1:3*COORD_BITS];
    got.last     = out_tlast;
    if (draw_queue.size() == 0) begin
      errors++;
      $display("%0t: unexpected command: expected none,", $time);
      $display("  got cmd=%0d (%0d,%0d)-(%0d,%0d) last=%0b",
               got.cmd, got.left_x, got.top_y, got.right_x, got.bottom_y, got.last);
    end else begin
      want = draw_queue.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: command mismatch: expected cmd=%0d (%0d,%0d)-(%0d,%0d) last=%0b,",
                 $time, want.cmd, want.left_x, want.top_y, want.right_x, want.bottom_y,
                 want.last);
        $display("  got cmd=%0d (%0d,%0d)-(%0d,%0d) last=%0b",
                 got.cmd, got.left_x, got.top_y, got.right_x, got.bottom_y, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      scr_w    = bsre_pkg::SCREEN_W_RST;
      scr_h    = bsre_pkg::SCREEN_H_RST;
      mod_w    = bsre_pkg::CODE_W_RST;
      mod_h    = bsre_pkg::CODE_H_RST;
      in_frame = 1'b0;
      row      = '0;
      col      = '0;
      pitch    = '0;
      org_x    = '0;
      org_y    = '0;
      draw_queue.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          bsre_pkg::REG_SCREEN_W: scr_w = cfg_pwdata[bsre_pkg::SCR_BITS-1:0];
          bsre_pkg::REG_SCREEN_H: scr_h = cfg_pwdata[bsre_pkg::SCR_BITS-1:0];
          bsre_pkg::REG_CODE_W:   mod_w = cfg_pwdata[bsre_pkg::CODE_BITS-1:0];
          bsre_pkg::REG_CODE_H:   mod_h = cfg_pwdata[bsre_pkg::CODE_BITS-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        render_byte(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        check_command();
      end
    end
    fail_count    <= errors;
    pending_count <= draw_queue.size();
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Bitmap rectangle emitter testbench
// Drives bitmap bytes under a range of screen and bitmap geometries, first a
// short directed list of corner cases, then random frames, whole and broken.
// The sender works in bursts and the receiver stalls, once for a long stretch.
// The draw command monitor predicts and checks every command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int COORD_BITS    = 12;
  localparam int OUT_BITS      = ((4*COORD_BITS+7)/8)*8;
  localparam int TOTAL_ITEMS   = 330;
  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [10:0] RX_PATTERN_BITS = 11'b10110011101;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

  logic                           clk;
  logic                           rst_n;
  logic [7:0]                     in_tdata;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [OUT_BITS-1:0]            out_tdata;
  logic [1:0]                     out_tuser;
  logic                           out_tlast;
  logic                           out_tvalid;
  logic                           out_tready;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [bsre_pkg::ADDR_BITS-1:0] cfg_paddr;
  logic [bsre_pkg::DATA_BITS-1:0] cfg_pwdata;
  logic [bsre_pkg::DATA_BITS-1:0] cfg_prdata;
  logic                           cfg_pready;

  int       mismatches;
  int       awaiting;
  int       items_sent = 0;
  int       burst_left = 0;
  int       gap_max    = 0;
  int       hold_req   = 0;
  rx_mode_t rx_mode    = RX_ALWAYS;

  bitmap_scaled_rect_emitter_core #(
    .COORD_BITS (COORD_BITS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  bsre_draw_monitor #(
    .COORD_BITS (COORD_BITS)
  ) draw_mon (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tdata      (in_tdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .fail_count    (mismatches),
    .pending_count (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  // The receiver follows its own stall pattern and serves long hold-off requests.
  initial begin
    int hold_left;
    int hold_served;
    int pat_idx;
    hold_left   = 0;
    hold_served = 0;
    pat_idx     = 0;
    out_tready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_served != hold_req) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  out_tready <= 1'b1;
          RX_RANDOM:  out_tready <= ($urandom_range(0, 99) < 70);
          RX_PATTERN: out_tready <= RX_PATTERN_BITS[pat_idx];
          default:    out_tready <= ($urandom_range(0, 3) == 0);
        endcase
        pat_idx = (pat_idx == 10) ? 0 : pat_idx + 1;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    mask = (idx == bsre_pkg::REG_SCREEN_W || idx == bsre_pkg::REG_SCREEN_H) ?
           32'hFFF : 32'hFF;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= ($urandom() & ~mask) | (value & mask);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_geometry(input int sw, input int sh, input int cw, input int ch);
    write_reg(bsre_pkg::REG_SCREEN_W, sw);
    write_reg(bsre_pkg::REG_SCREEN_H, sh);
    write_reg(bsre_pkg::REG_CODE_W, cw);
    write_reg(bsre_pkg::REG_CODE_H, ch);
  endtask

  task automatic send_byte(input logic [7:0] pixels);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tdata  <= pixels;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    items_sent++;
  endtask

  task automatic quiesce();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int   phase_no;
    int   frames;
    int   per_frame;
    int   count;
    int   sw;
    int   sh;
    int   cw;
    int   ch;
    bit   broken;
    logic [7:0] pix;

    rst_n       = 1'b0;
    in_tdata    = '0;
    in_tvalid   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corner cases.
    rx_mode = RX_PATTERN;
    gap_max = 2;
    send_byte(8'h00);
    quiesce();
    load_geometry(240, 240, 8, 1);
    send_byte(8'hFF);
    quiesce();
    load_geometry(4000, 4095, 1, 3);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h3F);
    quiesce();
    load_geometry(300, 100, 9, 3);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'hA5);
    quiesce();
    load_geometry(100, 200, 0, 2);
    send_byte(8'h00);
    send_byte(8'hFF);
    quiesce();
    load_geometry(40, 90, 5, 0);
    send_byte(8'h00);
    quiesce();
    load_geometry(200, 100, 7, 0);
    send_byte(8'h12);
    quiesce();
    load_geometry(1, 1, 1, 1);
    send_byte(8'h7F);
    quiesce();
    load_geometry(4095, 4095, 2, 2);
    send_byte(8'h3F);
    send_byte(8'h00);
    quiesce();

    // Random frames, mostly complete, some cut short.
    phase_no = 0;
    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 7))
        0: begin
          sw = $urandom_range(0, 1) ? 4095 : 1;
          sh = $urandom_range(0, 1) ? 4095 : 1;
        end
        1, 2: begin
          sw = $urandom_range(1, 4095);
          sh = $urandom_range(1, 4095);
        end
        default: begin
          sw = $urandom_range(16, 480);
          sh = $urandom_range(16, 480);
        end
      endcase
      cw = $urandom_range(1, 24);
      ch = $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) cw = 0;
      if ($urandom_range(0, 9) == 0) ch = 0;
      frames  = $urandom_range(1, 3);
      broken  = ($urandom_range(0, 4) == 0);
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      case ($urandom_range(0, 2))
        0:       gap_max = 0;
        1:       gap_max = 3;
        default: gap_max = 12;
      endcase
      if (phase_no == 2) begin
        cw      = 20;
        ch      = 4;
        frames  = 3;
        broken  = 1'b0;
        gap_max = 0;
        rx_mode = RX_RANDOM;
      end else if (phase_no == 3) begin
        cw     = 255;
        ch     = 1;
        frames = 1;
        broken = 1'b0;
      end else if (phase_no == 5) begin
        ch     = 255;
        broken = 1'b1;
      end
      load_geometry(sw, sh, cw, ch);
      per_frame = (ch == 0) ? 1 : (((cw + 7) / 8 == 0) ? 1 : (cw + 7) / 8) * ch;
      if (phase_no == 5) begin
        count = $urandom_range(4, 10);
      end else if (broken) begin
        count = $urandom_range(1, per_frame);
      end else begin
        count = frames * per_frame;
      end
      if (phase_no == 2) begin
        hold_req++;
      end
      repeat (count) begin
        case ($urandom_range(0, 7))
          0:       pix = 8'h00;
          1:       pix = 8'hFF;
          default: pix = 8'($urandom_range(0, 255));
        endcase
        send_byte(pix);
      end
      quiesce();
      phase_no++;
    end

    if (mismatches == 0 && awaiting == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
